// ===== rtl/idq_pkg.sv =====
// Shared types and constants of the indexed deque with fill unit.
package idq_pkg;

  // Fixed widths of the transaction fields.
  localparam int ACT_W    = 3;
  localparam int IDX_W    = 11;
  localparam int VAL_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SHIFT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNSHIFT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SET     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_EXISTS  = 3'd6;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd7;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } idq_state_t;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic                exists_flag;
    logic [LEN_W-1:0]    length;
  } idq_result_t;

endpackage

// ===== rtl/idq_if.sv =====
// Channel interfaces of the indexed deque with fill unit.

// Request channel: one action per transaction.
interface idq_req_if;
  logic                                valid;
  logic                                ready;
  logic [idq_pkg::ACT_W-1:0]           action;
  logic signed [idq_pkg::IDX_W-1:0]    index;
  logic [idq_pkg::VAL_W-1:0]           value;

  modport source (output valid, action, index, value, input ready);
  modport sink   (input valid, action, index, value, output ready);
endinterface

// Response channel: one result per request.
interface idq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [idq_pkg::DATA_W-1:0]         data_out;
  logic [idq_pkg::STATUS_W-1:0]       status;
  logic                               exists_flag;
  logic [idq_pkg::LEN_W-1:0]          length;

  modport source (output valid, data_out, status, exists_flag, length, input ready);
  modport sink   (input valid, data_out, status, exists_flag, length, output ready);
endinterface

// Configuration channel: writes the fill value register.
interface idq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [idq_pkg::VAL_W-1:0]   fill_value;

  modport source (output valid, fill_value, input ready);
  modport sink   (input valid, fill_value, output ready);
endinterface

// ===== rtl/idq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; returns the contents before a same-edge write.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/indexed_deque_with_fill_unit.sv =====
// Top level of the indexed deque with fill unit.
//
// A bounded double-ended array of DEPTH elements kept in one ring RAM, with a head
// pointer and an element count in registers. Push, unshift, exists, clear, a set
// inside the current length and every failing request finish in the idle state,
// and a request can be accepted every cycle for them while rsp.ready is high. Pop,
// shift and a get inside the length pass through the read state, as the RAM read
// data is registered. A get or set at or past the length writes one new slot per
// cycle through the RAM write port in the fill state, up to the resolved index.
// A finished result waits in an output register; a new request is taken when the
// sequencer is idle and that register is empty or being emptied. The slot RAM
// needs no clearing pass after reset; configuration writes are taken every cycle.
module indexed_deque_with_fill_unit #(
  parameter int DEPTH      = 1024,
  parameter int ELEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  idq_req_if.sink   req,
  idq_rsp_if.source rsp,
  idq_cfg_if.sink   cfg
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (CNT_W > idq_pkg::IDX_W) ? CNT_W : idq_pkg::IDX_W;
  localparam int EW    = ELEM_WIDTH;

  localparam logic [AW:0]       DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [POS_W-1:0]  DEPTH_P = POS_W'(DEPTH);
  localparam logic [CNT_W-1:0]  FULL_C  = CNT_W'(DEPTH);
  localparam logic [AW-1:0]     LAST_A  = AW'(DEPTH - 1);

  // Ring position: base plus offset, both below DEPTH, wrapped once.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  // Registers.
  idq_pkg::idq_state_t  state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [idq_pkg::VAL_W-1:0] fill_value;
  logic                 rsp_valid;
  idq_pkg::idq_result_t rsp_q;
  logic [AW-1:0]        fill_target;
  logic                 fill_set;
  logic [EW-1:0]        item_val;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  // Control signals of the sequencer.
  idq_pkg::idq_result_t res_next;
  logic                 rsp_load;
  logic                 rsp_done;
  logic                 fill_start;
  logic                 req_fire;

  // Index resolution signals.
  logic [idq_pkg::IDX_W-1:0] idx_u;
  logic [idq_pkg::IDX_W-1:0] back_u;
  logic [POS_W-1:0]          cnt_p;
  logic [POS_W-1:0]          pos;
  logic                      idx_neg;
  logic                      resolve_ok;
  logic                      in_len;
  logic [AW-1:0]             pos_a;

  // Ring address path.
  logic [AW-1:0] ring_off;
  logic [AW-1:0] ring_pos;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;

  logic [EW-1:0] val_elem;
  logic [EW-1:0] fill_elem;
  logic          fill_last;

  idq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshakes.
  assign req.ready = (state == idq_pkg::S_IDLE) && (!rsp_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid       = rsp_valid;
  assign rsp.data_out    = rsp_q.data_out;
  assign rsp.status      = rsp_q.status;
  assign rsp.exists_flag = rsp_q.exists_flag;
  assign rsp.length      = rsp_q.length;

  assign val_elem  = EW'(req.value);
  assign fill_elem = EW'(fill_value);

  // Resolve the signed index; a negative one counts back from the length.
  assign idx_u      = req.index;
  assign idx_neg    = idx_u[idq_pkg::IDX_W-1];
  assign back_u     = (~idx_u) + idq_pkg::IDX_W'(1);
  assign cnt_p      = POS_W'(count);
  assign pos        = idx_neg ? (cnt_p - POS_W'(back_u)) : POS_W'(idx_u);
  assign resolve_ok = (!idx_neg || (POS_W'(back_u) <= cnt_p)) && (pos < DEPTH_P);
  assign in_len     = pos < cnt_p;
  assign pos_a      = pos[AW-1:0];

  // Offset into the ring: the tail while filling, else chosen by the action.
  always_comb begin
    ring_off = count[AW-1:0];
    if (state == idq_pkg::S_IDLE) begin
      case (req.action)
        idq_pkg::ACT_POP:                  ring_off = AW'(count - CNT_W'(1));
        idq_pkg::ACT_GET, idq_pkg::ACT_SET: ring_off = pos_a;
        default:                           ring_off = count[AW-1:0];
      endcase
    end
  end

  assign ring_pos  = ring_add(head, ring_off);
  assign head_inc  = (head == LAST_A) ? '0 : head + AW'(1);
  assign head_dec  = (head == '0) ? LAST_A : head - AW'(1);
  assign fill_last = count[AW-1:0] == fill_target;

  // Sequencer: decodes a request, reads or writes the ring, builds the result.
  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    ram_we      = 1'b0;
    ram_waddr   = ring_pos;
    ram_wdata   = val_elem;
    ram_raddr   = ring_pos;
    rsp_load    = 1'b0;
    rsp_done    = 1'b0;
    fill_start  = 1'b0;
    res_next    = '0;

    case (state)
      idq_pkg::S_IDLE: begin
        if (req_fire) begin
          rsp_load = 1'b1;
          rsp_done = 1'b1;
          case (req.action)
            idq_pkg::ACT_PUSH: begin
              if (count == FULL_C) begin
                res_next.status = idq_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            idq_pkg::ACT_POP: begin
              if (count == '0) begin
                res_next.status = idq_pkg::ST_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
                if (count == CNT_W'(1)) begin
                  head_next = '0;
                end
                rsp_done   = 1'b0;
                state_next = idq_pkg::S_READ;
              end
            end
            idq_pkg::ACT_SHIFT: begin
              if (count == '0) begin
                res_next.status = idq_pkg::ST_EMPTY;
              end else begin
                ram_raddr  = head;
                count_next = count - CNT_W'(1);
                head_next  = (count == CNT_W'(1)) ? '0 : head_inc;
                rsp_done   = 1'b0;
                state_next = idq_pkg::S_READ;
              end
            end
            idq_pkg::ACT_UNSHIFT: begin
              if (count == FULL_C) begin
                res_next.status = idq_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = head_dec;
                head_next  = head_dec;
                count_next = count + CNT_W'(1);
              end
            end
            idq_pkg::ACT_GET, idq_pkg::ACT_SET: begin
              if (!resolve_ok) begin
                res_next.status = idq_pkg::ST_RANGE;
              end else if (!in_len) begin
                // Past the length: extend slot by slot first.
                rsp_load   = 1'b0;
                rsp_done   = 1'b0;
                fill_start = 1'b1;
                state_next = idq_pkg::S_FILL;
              end else if (req.action == idq_pkg::ACT_GET) begin
                rsp_done   = 1'b0;
                state_next = idq_pkg::S_READ;
              end else begin
                ram_we = 1'b1;
              end
            end
            idq_pkg::ACT_EXISTS: begin
              res_next.exists_flag = resolve_ok && in_len;
            end
            idq_pkg::ACT_CLEAR: begin
              count_next = '0;
              head_next  = '0;
            end
            default: begin
              rsp_load = 1'b0;
              rsp_done = 1'b0;
            end
          endcase
          res_next.length = idq_pkg::LEN_W'(count_next);
        end
      end

      idq_pkg::S_READ: begin
        // Read data is back; complete the result prepared at acceptance.
        res_next          = rsp_q;
        res_next.data_out = idq_pkg::DATA_W'(ram_rdata);
        rsp_load          = 1'b1;
        rsp_done          = 1'b1;
        state_next        = idq_pkg::S_IDLE;
      end

      idq_pkg::S_FILL: begin
        // Write the fill value at the tail; the last slot of a set takes the item.
        ram_we     = 1'b1;
        ram_wdata  = (fill_last && fill_set) ? item_val : fill_elem;
        count_next = count + CNT_W'(1);
        if (fill_last) begin
          res_next.data_out = fill_set ? '0 : idq_pkg::DATA_W'(fill_elem);
          res_next.status   = idq_pkg::ST_OK;
          res_next.length   = idq_pkg::LEN_W'(count_next);
          rsp_load          = 1'b1;
          rsp_done          = 1'b1;
          state_next        = idq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = idq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= idq_pkg::S_IDLE;
      head       <= '0;
      count      <= '0;
      fill_value <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (cfg.valid && cfg.ready) begin
        fill_value <= cfg.fill_value;
      end
      if (rsp_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_q <= res_next;
    end
    if (fill_start) begin
      fill_target <= pos_a;
      fill_set    <= req.action == idq_pkg::ACT_SET;
      item_val    <= val_elem;
    end
  end

  // The element count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_C)
    else $error("element count above capacity");

  // An empty array always has its head at ring position zero.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == '0))
    else $error("head not reset on empty array");

  // While a request is in progress no result is waiting.
  a_busy_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (state != idq_pkg::S_IDLE) |-> !rsp_valid)
    else $error("result pending during multi-cycle request");

  // Every fill cycle adds exactly one element.
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (state == idq_pkg::S_FILL) |=> (count == $past(count) + CNT_W'(1)))
    else $error("fill step did not add one element");

endmodule
